// File: hw/rtl/dtfp_pkg.sv
package dtfp_pkg;

   // Number of fraction digits kept in the result (2 gives hundredths).
   localparam int FRAC_DIGITS = 2;
   localparam int unsigned SCALE = 10 ** FRAC_DIGITS;
   localparam int CENTS_W = $clog2(SCALE);
   localparam int CNT_W = $clog2(FRAC_DIGITS + 2);
   localparam int WHOLE_W = 63;
   localparam int AMOUNT_W = 64;
   // whole * SCALE + fraction + round never reaches 2^(WHOLE_W + CENTS_W + 1).
   localparam int PROD_W = WHOLE_W + CENTS_W + 1;

   // Lane parse phases.
   localparam logic [1:0] PH_START = 2'd0;
   localparam logic [1:0] PH_INT   = 2'd1;
   localparam logic [1:0] PH_FRAC  = 2'd2;
   localparam logic [1:0] PH_BAD   = 2'd3;

   // Character codes.
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_APOS  = 8'h27;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef struct packed {
      logic [1:0]         phase;
      logic [WHOLE_W-1:0] whole;
      logic [CENTS_W-1:0] cents;
      logic [CNT_W-1:0]   count;
      logic               round_up;
      logic               int_seen;
      logic               frac_seen;
   } lane_state_type;

   localparam lane_state_type LANE_RESET = '{
      phase: PH_START, whole: '0, cents: '0, count: '0,
      round_up: 1'b0, int_seen: 1'b0, frac_seen: 1'b0
   };

endpackage

// File: hw/rtl/dtfp_lane.sv
module dtfp_lane (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     char_en,
   input  logic [7:0]               char_code,
   input  logic                     dot_lane,
   input  logic                     clear,
   output dtfp_pkg::lane_state_type lane_next,
   output logic                     sign_taken
);
   import dtfp_pkg::*;

   lane_state_type state_ff, state_in;
   logic [7:0] sep;
   logic       skipped;
   logic       is_digit;
   logic [3:0] digit;
   logic [WHOLE_W+3:0] whole_x10;
   logic [CENTS_W+3:0] cents_x10;

   assign sep      = dot_lane ? CH_DOT : CH_COMMA;
   assign skipped  = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
                     (char_code == CH_CR) || (char_code == CH_LF) ||
                     (char_code == CH_UNDER) || (char_code == CH_APOS) ||
                     (dot_lane && char_code == CH_COMMA);
   assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
   assign digit    = 4'(char_code - CH_ZERO);
   assign whole_x10 = (WHOLE_W+4)'(state_ff.whole) * (WHOLE_W+4)'(10)
                      + (WHOLE_W+4)'(digit);
   assign cents_x10 = (CENTS_W+4)'(state_ff.cents) * (CENTS_W+4)'(10)
                      + (CENTS_W+4)'(digit);

   always_comb begin
      lane_next  = state_ff;
      sign_taken = 1'b0;
      if (char_en && !skipped && state_ff.phase != PH_BAD) begin
         if (is_digit) begin
            if (state_ff.phase == PH_FRAC) begin
               if (state_ff.count < CNT_W'(FRAC_DIGITS)) begin
                  lane_next.cents = cents_x10[CENTS_W-1:0];
                  lane_next.count = state_ff.count + 1'b1;
               end else if (state_ff.count == CNT_W'(FRAC_DIGITS)) begin
                  lane_next.round_up = (digit >= 4'd5);
                  lane_next.count    = state_ff.count + 1'b1;
               end
               lane_next.frac_seen = 1'b1;
            end else if (whole_x10[WHOLE_W+3:WHOLE_W] != '0) begin
               // Whole units would pass the largest signed 64-bit value.
               lane_next.phase = PH_BAD;
            end else begin
               lane_next.whole    = whole_x10[WHOLE_W-1:0];
               lane_next.int_seen = 1'b1;
               lane_next.phase    = PH_INT;
            end
         end else if (char_code == CH_PLUS || char_code == CH_MINUS) begin
            if (state_ff.phase == PH_START) begin
               lane_next.phase = PH_INT;
               sign_taken      = 1'b1;
            end else begin
               lane_next.phase = PH_BAD;
            end
         end else if (char_code == sep && state_ff.phase != PH_FRAC) begin
            lane_next.phase = PH_FRAC;
         end else begin
            lane_next.phase = PH_BAD;
         end
      end
   end

   assign state_in = clear ? LANE_RESET : lane_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LANE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      $past(clear) |-> (state_ff.phase == PH_START && !state_ff.int_seen
                        && !state_ff.frac_seen))
      else $error("lane state not cleared after end of text");

   assert property (@(posedge clock) disable iff (reset)
      state_ff.round_up |-> (state_ff.count > CNT_W'(FRAC_DIGITS)))
      else $error("round flag set before all kept fraction digits");

   assert property (@(posedge clock) disable iff (reset)
      state_ff.frac_seen |-> (state_ff.phase == PH_FRAC || state_ff.phase == PH_BAD))
      else $error("fraction digit seen outside fraction part");

endmodule

// File: hw/rtl/dtfp_finish.sv
module dtfp_finish (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     take_valid,
   input  dtfp_pkg::lane_state_type take_lane,
   input  logic                     take_negative,
   output logic                     take_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [63:0]              rsp_amount,
   output logic                     rsp_ok
);
   import dtfp_pkg::*;

   function automatic logic [CENTS_W-1:0] pad_frac(input logic [CENTS_W-1:0] cents,
                                                    input logic [CNT_W-1:0] count);
      logic [CENTS_W-1:0] v;
      logic [CNT_W-1:0]   cnt;
      v   = cents;
      cnt = (count > CNT_W'(FRAC_DIGITS)) ? CNT_W'(FRAC_DIGITS) : count;
      for (int i = 0; i < FRAC_DIGITS; i++) begin
         if (i >= int'(cnt)) begin
            v = CENTS_W'(v * CENTS_W'(10));
         end
      end
      return v;
   endfunction

   // Stage A: snapshot of the chosen lane.
   logic           a_valid_ff, a_valid_in;
   lane_state_type a_lane_ff, a_lane_in;
   logic           a_neg_ff, a_neg_in;
   // Stage B: scaled total.
   logic              b_valid_ff, b_valid_in;
   logic [PROD_W-1:0] b_total_ff, b_total_in;
   logic              b_good_ff, b_good_in;
   logic              b_neg_ff, b_neg_in;
   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [AMOUNT_W-1:0] rsp_amount_ff, rsp_amount_in;
   logic                rsp_ok_ff, rsp_ok_in;

   logic rsp_slot, b_ready, a_ready;
   logic ok;
   logic [AMOUNT_W-1:0] mag;

   assign rsp_slot   = !rsp_valid_ff || rsp_ready;
   assign b_ready    = !b_valid_ff || rsp_slot;
   assign a_ready    = !a_valid_ff || b_ready;
   assign take_ready = a_ready;

   assign a_valid_in = a_ready ? take_valid : a_valid_ff;
   assign a_lane_in  = a_ready ? take_lane : a_lane_ff;
   assign a_neg_in   = a_ready ? take_negative : a_neg_ff;

   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   assign b_total_in = b_ready ?
      (PROD_W'(a_lane_ff.whole) * PROD_W'(SCALE)
       + PROD_W'(pad_frac(a_lane_ff.cents, a_lane_ff.count))
       + PROD_W'(a_lane_ff.round_up)) : b_total_ff;
   assign b_good_in  = b_ready ?
      (a_lane_ff.phase != PH_BAD && (a_lane_ff.int_seen || a_lane_ff.frac_seen))
      : b_good_ff;
   assign b_neg_in   = b_ready ? a_neg_ff : b_neg_ff;

   // The total fits only if nothing stands above the 63 magnitude bits.
   assign ok  = b_good_ff && (b_total_ff[PROD_W-1:WHOLE_W] == '0);
   assign mag = ok ? {1'b0, b_total_ff[WHOLE_W-1:0]} : '0;

   assign rsp_valid_in  = rsp_slot ? b_valid_ff : rsp_valid_ff;
   assign rsp_amount_in = rsp_slot ? (b_neg_ff ? (~mag + 1'b1) : mag) : rsp_amount_ff;
   assign rsp_ok_in     = rsp_slot ? ok : rsp_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_lane_ff     <= a_lane_in;
      a_neg_ff      <= a_neg_in;
      b_total_ff    <= b_total_in;
      b_good_ff     <= b_good_in;
      b_neg_ff      <= b_neg_in;
      rsp_amount_ff <= rsp_amount_in;
      rsp_ok_ff     <= rsp_ok_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_amount = rsp_amount_ff;
   assign rsp_ok     = rsp_ok_ff;

   assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !b_good_ff && rsp_slot) |=> (rsp_valid_ff && !rsp_ok_ff))
      else $error("malformed text produced an ok result");

   assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && b_ready) |=> b_valid_ff)
      else $error("snapshot lost between stages");

   assert property (@(posedge clock) disable iff (reset)
      !take_ready |-> (a_valid_ff && b_valid_ff && rsp_valid_ff))
      else $error("stall with an empty stage");

endmodule

// File: hw/rtl/decimal_text_to_fixed_point.sv
// The result of a text passes through stage A, stage B and the result register
// after the edge that accepts its last item. Texts may follow back to back.
// Throughput: one character item per cycle while req_tready is high.
// Three registered slots after the lanes absorb results while the output stalls.
// Reset is synchronous and active high; it clears both lanes and all valid bits.
//
// Each character goes through two parser lanes at once. Lane zero treats '.'
// as the decimal separator and skips commas; lane one treats ',' as the
// separator. When the last item of a text arrives, the lane state after that
// item is taken: lane zero if the text held any '.', lane one otherwise, and
// both lanes return to their start state. The finish path scales the whole
// units, adds the padded fraction and the half-up rounding, checks the total
// against the signed 64-bit range and applies the sign.
module decimal_text_to_fixed_point (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic [0:0]  req_tuser,   // [0] char_present
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] amount_hundredths
   output logic [0:0]  rsp_tuser    // [0] parse_ok
);
   import dtfp_pkg::*;

   logic accept;
   logic char_en;
   logic text_end;
   logic take_ready;

   logic dot_seen_ff, dot_seen_in, dot_next;
   logic is_negative_ff, is_negative_in, neg_next;

   lane_state_type lane0_next, lane1_next;
   logic           sign0_taken, sign1_taken;
   logic           rsp_ok;

   assign req_tready = take_ready;
   assign accept     = req_tvalid && req_tready;
   assign char_en    = accept && req_tuser[0];
   assign text_end   = accept && req_tlast;

   // A '.' anywhere decides for lane zero; the sign comes from lane zero only.
   assign dot_next = dot_seen_ff || (char_en && req_tdata == CH_DOT);
   assign neg_next = sign0_taken ? (req_tdata == CH_MINUS) : is_negative_ff;

   assign dot_seen_in    = text_end ? 1'b0 : dot_next;
   assign is_negative_in = text_end ? 1'b0 : neg_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_seen_ff    <= 1'b0;
         is_negative_ff <= 1'b0;
      end else begin
         dot_seen_ff    <= dot_seen_in;
         is_negative_ff <= is_negative_in;
      end
   end

   dtfp_lane u_lane_dot (
      .clock      (clock),
      .reset      (reset),
      .char_en    (char_en),
      .char_code  (req_tdata),
      .dot_lane   (1'b1),
      .clear      (text_end),
      .lane_next  (lane0_next),
      .sign_taken (sign0_taken)
   );

   // Lane one's sign acceptance is not used; the sign is lane zero's.
   dtfp_lane u_lane_comma (
      .clock      (clock),
      .reset      (reset),
      .char_en    (char_en),
      .char_code  (req_tdata),
      .dot_lane   (1'b0),
      .clear      (text_end),
      .lane_next  (lane1_next),
      .sign_taken (sign1_taken)
   );

   dtfp_finish u_finish (
      .clock         (clock),
      .reset         (reset),
      .take_valid    (text_end),
      .take_lane     (dot_next ? lane0_next : lane1_next),
      .take_negative (neg_next),
      .take_ready    (take_ready),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_amount    (rsp_tdata),
      .rsp_ok        (rsp_ok)
   );

   assign rsp_tuser = rsp_ok;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == 64'd0))
      else $error("invalid result with nonzero amount");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata != 64'h8000_0000_0000_0000))
      else $error("amount outside the symmetric range");

   assert property (@(posedge clock) disable iff (reset)
      text_end |=> (!dot_seen_ff && !is_negative_ff))
      else $error("text flags not cleared after end of text");

   assert property (@(posedge clock) disable iff (reset)
      (char_en && sign1_taken) |-> (lane1_next.phase == PH_INT))
      else $error("lane one took a sign without entering the integer part");

endmodule
